// ----- hdl/c8x_pkg.sv -----
package c8x_pkg;

    localparam int ADDR_W = 12;
    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        REQ_EXEC  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_ROW   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLS,
        ST_RET,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_DRAW_ROW,
        ST_BCD,
        ST_STORE,
        ST_LOAD_RD,
        ST_LOAD_WAIT,
        ST_LOAD_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] instr;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [15:0] keys;
        logic [7:0]  rand_byte;
        logic [4:0]  display_row;
    } t_in;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        redraw;
        logic        waiting_key;
        logic        bad_opcode;
        logic        sound_on;
        logic [63:0] row_pixels;
    } t_out;

endpackage

// ----- hdl/c8x_if.sv -----
interface c8x_in_if import c8x_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c8x_out_if import c8x_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/chip8_instruction_execute.sv -----
// each item: decode, then a response state that waits for the receiver, then idle;
// return adds a stack read; bcd adds tens and ones writes; clear screen clears one
// frame row per cycle; draw reads, waits, writes per sprite row; Fx55 stores V0..Vx;
// Fx65 reads, waits, loads per register; one item in flight, ready only when idle
// reset (i_rst_n low, synchronous): registers, timers, stack pointer, flags and frame
// cleared, pc at 0x200; memory and return stack contents stay undefined
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c8x_in_if.sink     i_req,
    c8x_out_if.source  o_rsp
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    // state
    t_state r_state, n_state;
    t_in    r_in, n_in;
    logic [7:0]  r_v [16];
    logic [63:0] r_frame [32];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  r_mem [4096];
    logic [SP_W-1:0] r_sp, n_sp;
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_i, n_i;
    logic [7:0]  r_dt, n_dt;
    logic [7:0]  r_st, n_st;
    logic        r_halt, n_halt;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_redraw, n_redraw;
    logic        r_wait, n_wait;
    logic        r_vf, n_vf;
    logic [63:0] r_row, n_row;
    logic [7:0]  r_rd;
    logic [11:0] r_srd;
    t_out        r_out, n_out;

    // shared memory port
    logic        mem_we;
    logic [11:0] mem_wa;
    logic [7:0]  mem_wd;
    logic [11:0] mem_ra;
    // register file write port
    logic        v_we;
    logic [3:0]  v_wa;
    logic [7:0]  v_wd;
    logic        vf_we;
    logic [7:0]  vf_wd;
    // frame write port
    logic        f_we;
    logic [4:0]  f_wa;
    logic [63:0] f_wd;
    logic        f_clr;
    logic        s_we;

    logic [3:0]  op, xi, yi, nn;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  sum;
    logic [63:0] spr, cur_row;
    logic [4:0]  yy;
    logic [5:0]  vx6;
    logic [127:0] spr_w;
    logic        key_hit;
    logic [3:0]  key_hi;
    logic        key_any;
    logic [7:0]  hund, tens, ones;

    assign op  = r_in.instr[15:12];
    assign xi  = r_in.instr[11:8];
    assign yi  = r_in.instr[7:4];
    assign nn  = r_in.instr[3:0];
    assign kk  = r_in.instr[7:0];
    assign nnn = r_in.instr[11:0];
    assign vx  = r_v[xi];
    assign vy  = r_v[yi];
    assign yy  = vy[4:0] + r_cnt;
    assign vx6 = vx[5:0];
    assign cur_row = r_frame[yy];
    // place sprite byte at column vx with wrap
    assign spr_w = {r_rd, 120'd0} >> vx6;
    assign spr   = spr_w[127:64] | spr_w[63:0];
    assign key_hit = (vx < 8'd16) && r_in.keys[vx[3:0]];

    always_comb begin
        key_hi  = 4'd0;
        key_any = 1'b0;
        for (int k = 0; k < 16; k++) begin
            if (r_in.keys[k]) begin
                key_hi  = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    // bcd: hundreds by compare/subtract, tens by multiply by 205 and shift by 11, ones by remainder
    always_comb begin
        logic [7:0] t;
        t    = vx;
        hund = 8'd0;
        if (t >= 8'd200) begin
            hund = 8'd2;
            t    = t - 8'd200;
        end else if (t >= 8'd100) begin
            hund = 8'd1;
            t    = t - 8'd100;
        end
        tens = 8'((16'(t) * 16'd205) >> 11);
        ones = t - 8'(tens * 8'd10);
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_DONE);
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_sp     = r_sp;
        n_pc     = r_pc;
        n_i      = r_i;
        n_dt     = r_dt;
        n_st     = r_st;
        n_halt   = r_halt;
        n_cnt    = r_cnt;
        n_redraw = r_redraw;
        n_wait   = r_wait;
        n_vf     = r_vf;
        n_row    = r_row;
        n_out    = r_out;
        mem_we = 1'b0;
        mem_wa = r_i;
        mem_wd = 8'd0;
        mem_ra = r_i + 12'(r_cnt);
        v_we   = 1'b0;
        v_wa   = xi;
        v_wd   = 8'd0;
        vf_we  = 1'b0;
        vf_wd  = 8'd0;
        f_we   = 1'b0;
        f_wa   = yy;
        f_wd   = 64'd0;
        f_clr  = 1'b0;
        s_we   = 1'b0;
        sum    = 9'd0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_in     = i_req.data;
                    n_cnt    = 5'd0;
                    n_redraw = 1'b0;
                    n_wait   = 1'b0;
                    n_row    = 64'd0;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_DONE;
                case (t_req'(r_in.req_type))
                    REQ_LOAD: begin
                        mem_we = 1'b1;
                        mem_wa = r_in.mem_addr;
                        mem_wd = r_in.mem_data;
                    end
                    REQ_TICK: begin
                        if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                        if (r_st != 8'd0) n_st = r_st - 8'd1;
                    end
                    REQ_ROW: n_row = r_frame[r_in.display_row];
                    default: begin
                        if (!r_halt) begin
                            case (op)
                                4'h0: begin
                                    if (nnn == 12'h0E0) begin
                                        n_redraw = 1'b1;
                                        n_pc     = r_pc + 12'd2;
                                        n_state  = ST_CLS;
                                    end else if (nnn == 12'h0EE) begin
                                        // stack pointer wraps modulo the depth
                                        n_sp    = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1)
                                                               : r_sp - 1'b1;
                                        n_state = ST_RET;
                                    end else begin
                                        n_pc = nnn;
                                    end
                                end
                                4'h1: n_pc = nnn;
                                4'h2: begin
                                    s_we = 1'b1;
                                    n_sp = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0
                                                                            : r_sp + 1'b1;
                                    n_pc = nnn;
                                end
                                4'h3: n_pc = r_pc + ((vx == kk) ? 12'd4 : 12'd2);
                                4'h4: n_pc = r_pc + ((vx != kk) ? 12'd4 : 12'd2);
                                4'h5: n_pc = r_pc + ((vx == vy) ? 12'd4 : 12'd2);
                                4'h6: begin
                                    v_we = 1'b1;
                                    v_wd = kk;
                                    n_pc = r_pc + 12'd2;
                                end
                                4'h7: begin
                                    v_we = 1'b1;
                                    v_wd = vx + kk;
                                    n_pc = r_pc + 12'd2;
                                end
                                4'h8: begin
                                    n_pc = r_pc + 12'd2;
                                    v_we = 1'b1;
                                    case (nn)
                                        4'h0: v_wd = vy;
                                        4'h1: v_wd = vx | vy;
                                        4'h2: v_wd = vx & vy;
                                        4'h3: v_wd = vx ^ vy;
                                        4'h4: begin
                                            sum   = {1'b0, vx} + {1'b0, vy};
                                            vf_we = 1'b1;
                                            vf_wd = {7'd0, sum[8]};
                                            v_wd  = sum[7:0];
                                        end
                                        4'h5: begin
                                            vf_we = 1'b1;
                                            vf_wd = {7'd0, vx > vy};
                                            v_wd  = vx - vy;
                                        end
                                        4'h6: begin
                                            vf_we = 1'b1;
                                            vf_wd = {7'd0, vx[0]};
                                            v_wd  = {1'b0, vx[7:1]};
                                        end
                                        4'h7: begin
                                            vf_we = 1'b1;
                                            vf_wd = {7'd0, vy > vx};
                                            v_wd  = vy - vx;
                                        end
                                        4'hE: begin
                                            vf_we = 1'b1;
                                            vf_wd = {7'd0, vx[7]};
                                            v_wd  = {vx[6:0], 1'b0};
                                        end
                                        default: begin
                                            v_we   = 1'b0;
                                            n_halt = 1'b1;
                                            n_pc   = r_pc;
                                        end
                                    endcase
                                end
                                4'h9: begin
                                    if (nn != 4'd0) n_halt = 1'b1;
                                    else n_pc = r_pc + ((vx != vy) ? 12'd4 : 12'd2);
                                end
                                4'hA: begin
                                    n_i  = nnn;
                                    n_pc = r_pc + 12'd2;
                                end
                                4'hB: n_pc = nnn + {4'd0, r_v[0]};
                                4'hC: begin
                                    v_we = 1'b1;
                                    v_wd = r_in.rand_byte & kk;
                                    n_pc = r_pc + 12'd2;
                                end
                                4'hD: begin
                                    n_redraw = 1'b1;
                                    n_vf     = 1'b0;
                                    n_pc     = r_pc + 12'd2;
                                    n_state  = (nn == 4'd0) ? ST_DONE : ST_DRAW_RD;
                                    vf_we    = (nn == 4'd0);
                                end
                                4'hE: begin
                                    if (kk == 8'h9E)
                                        n_pc = r_pc + (key_hit ? 12'd4 : 12'd2);
                                    else if (kk == 8'hA1)
                                        n_pc = r_pc + (key_hit ? 12'd2 : 12'd4);
                                    else
                                        n_halt = 1'b1;
                                end
                                default: begin
                                    n_pc = r_pc + 12'd2;
                                    case (kk)
                                        8'h07: begin
                                            v_we = 1'b1;
                                            v_wd = r_dt;
                                        end
                                        8'h0A: begin
                                            if (key_any) begin
                                                v_we = 1'b1;
                                                v_wd = {4'd0, key_hi};
                                            end else begin
                                                n_wait = 1'b1;
                                                n_pc   = r_pc;
                                            end
                                        end
                                        8'h15: n_dt = vx;
                                        8'h18: n_st = vx;
                                        8'h1E: n_i = r_i + {4'd0, vx};
                                        // font address vx * 5 as 4x + x
                                        8'h29: n_i = ({4'd0, vx} << 2) + {4'd0, vx};
                                        8'h33: begin
                                            mem_we  = 1'b1;
                                            mem_wd  = hund;
                                            n_state = ST_BCD;
                                        end
                                        8'h55: n_state = ST_STORE;
                                        8'h65: n_state = ST_LOAD_RD;
                                        default: begin
                                            n_halt = 1'b1;
                                            n_pc   = r_pc;
                                        end
                                    endcase
                                end
                            endcase
                        end
                    end
                endcase
            end
            // clear one frame row per cycle
            ST_CLS: begin
                f_clr = 1'b1;
                f_wa  = r_cnt;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = ST_DONE;
            end
            // return address was read from the stack at the decode edge
            ST_RET: begin
                n_pc    = r_srd + 12'd2;
                n_state = ST_DONE;
            end
            ST_DRAW_RD:   n_state = ST_DRAW_WAIT;
            ST_DRAW_WAIT: n_state = ST_DRAW_ROW;
            ST_DRAW_ROW: begin
                f_we = 1'b1;
                f_wd = cur_row ^ spr;
                if ((cur_row & spr) != 64'd0) n_vf = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt + 5'd1 == {1'b0, nn}) begin
                    vf_we   = 1'b1;
                    vf_wd   = {7'd0, n_vf};
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DRAW_RD;
                end
            end
            ST_BCD: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    mem_wa = r_i + 12'd1;
                    mem_wd = tens;
                end else begin
                    mem_wa  = r_i + 12'd2;
                    mem_wd  = ones;
                    n_state = ST_DONE;
                end
            end
            ST_STORE: begin
                mem_we = 1'b1;
                mem_wa = r_i + 12'(r_cnt);
                mem_wd = r_v[r_cnt[3:0]];
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt[3:0] == xi) n_state = ST_DONE;
            end
            ST_LOAD_RD:   n_state = ST_LOAD_WAIT;
            ST_LOAD_WAIT: n_state = ST_LOAD_WR;
            ST_LOAD_WR: begin
                v_we  = 1'b1;
                v_wa  = r_cnt[3:0];
                v_wd  = r_rd;
                n_cnt = r_cnt + 5'd1;
                n_state = (r_cnt[3:0] == xi) ? ST_DONE : ST_LOAD_RD;
            end
            ST_DONE: begin
                if (o_rsp.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        n_out.next_pc     = n_pc;
        n_out.redraw      = n_redraw;
        n_out.waiting_key = n_wait;
        n_out.bad_opcode  = n_halt;
        n_out.sound_on    = (n_st != 8'd0);
        n_out.row_pixels  = n_row;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sp    <= '0;
            r_pc    <= PC_RESET;
            r_i     <= 12'd0;
            r_dt    <= 8'd0;
            r_st    <= 8'd0;
            r_halt  <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_dt    <= n_dt;
            r_st    <= n_st;
            r_halt  <= n_halt;
            if (v_we) r_v[v_wa] <= v_wd;
            // flag written after vx so it wins only when x is not F
            if (vf_we && !(v_we && v_wa == 4'hF && r_state == ST_DECODE)) r_v[15] <= vf_wd;
        end
    end

    // frame: reset clears all rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_frame[k] <= 64'd0;
        end else if (f_clr) begin
            r_frame[f_wa] <= 64'd0;
        end else if (f_we) begin
            r_frame[f_wa] <= f_wd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_cnt    <= n_cnt;
        r_redraw <= n_redraw;
        r_wait   <= n_wait;
        r_vf     <= n_vf;
        r_row    <= n_row;
        r_out    <= n_out;
        if (s_we) r_stack[r_sp] <= r_pc;
        r_srd <= r_stack[n_sp];
    end

    // program memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    // a response is only shown after a request was taken
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) != ST_IDLE)
        else $error("response without request");
    // halt never clears without reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) |-> r_halt)
        else $error("halt cleared");
    // no new request while busy
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_req.ready)
        else $error("ready while busy");

endmodule

// ----- tb/sv/tb_chip8_instruction_execute.sv -----
`timescale 1ns / 100ps

module tb_chip8_instruction_execute;
    import c8x_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 700;

    // opcode nibbles
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // 8xyN sub-operations
    localparam logic [3:0] AL_MOV  = 4'h0;
    localparam logic [3:0] AL_OR   = 4'h1;
    localparam logic [3:0] AL_AND  = 4'h2;
    localparam logic [3:0] AL_XOR  = 4'h3;
    localparam logic [3:0] AL_ADD  = 4'h4;
    localparam logic [3:0] AL_SUB  = 4'h5;
    localparam logic [3:0] AL_SHR  = 4'h6;
    localparam logic [3:0] AL_SUBN = 4'h7;
    localparam logic [3:0] AL_SHL  = 4'hE;
    localparam logic [3:0] AL_BAD  = 4'h8;

    // 0nnn special addresses
    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;

    // Ex and Fx low bytes
    localparam logic [7:0] K_SKP  = 8'h9E;
    localparam logic [7:0] K_SKNP = 8'hA1;
    localparam logic [7:0] F_GDT  = 8'h07;
    localparam logic [7:0] F_WKEY = 8'h0A;
    localparam logic [7:0] F_SDT  = 8'h15;
    localparam logic [7:0] F_SST  = 8'h18;
    localparam logic [7:0] F_ADI  = 8'h1E;
    localparam logic [7:0] F_FONT = 8'h29;
    localparam logic [7:0] F_BCD  = 8'h33;
    localparam logic [7:0] F_STR  = 8'h55;
    localparam logic [7:0] F_LDR  = 8'h65;

    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    c8x_in_if  req_if();
    c8x_out_if rsp_if();

    chip8_instruction_execute #(.STACK_DEPTH(STACK_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow machine state
    logic [7:0]  vreg_q [16];
    logic [7:0]  mem_q  [4096];
    bit          mem_ok [4096];
    logic [63:0] frame_q [32];
    logic [11:0] stk_q  [STACK_DEPTH];
    bit          stk_ok [STACK_DEPTH];
    logic [3:0]  sp_q;
    logic [11:0] pc_q;
    logic [11:0] idx_q;
    logic [7:0]  dt_q;
    logic [7:0]  st_q;
    bit          halt_q;

    // results still owed by the block, oldest first
    t_out pending_q[$];

    int errors = 0;
    int src_idle = 0;
    int snk_stall = 0;
    bit hold_req = 0;
    int quiet_cycles = 0;

    dir_row_t dir_tab[$];

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    function automatic t_in mk_exec(input logic [15:0] ins, input logic [15:0] keys,
                                    input logic [7:0] rnd);
        t_in b;
        b = '0;
        b.req_type = REQ_EXEC;
        b.instr = ins;
        b.keys = keys;
        b.rand_byte = rnd;
        return b;
    endfunction

    function automatic t_in mk_load(input logic [11:0] a, input logic [7:0] d);
        t_in b;
        b = '0;
        b.req_type = REQ_LOAD;
        b.mem_addr = a;
        b.mem_data = d;
        return b;
    endfunction

    function automatic t_in mk_other(input t_req kind, input logic [4:0] row);
        t_in b;
        b = '0;
        b.req_type = kind;
        b.display_row = row;
        return b;
    endfunction

    function automatic logic [15:0] ins(input logic [3:0] op, input logic [3:0] x,
                                       input logic [3:0] y, input logic [3:0] n);
        return {op, x, y, n};
    endfunction

    // advance the shadow machine by one beat and return the outcome
    function automatic t_out predict_outcome(input t_in b);
        t_out r;
        logic [3:0] op, x, y, n;
        logic [7:0] kk, vx, vy, bits;
        logic [11:0] nnn;
        logic [8:0] sum;
        logic [63:0] m;
        logic [4:0] yy;
        logic [5:0] xx;
        int step;
        bit any;
        r = '0;
        case (b.req_type)
            REQ_EXEC: if (!halt_q) begin
                op = b.instr[15:12];
                x = b.instr[11:8];
                y = b.instr[7:4];
                n = b.instr[3:0];
                kk = b.instr[7:0];
                nnn = b.instr[11:0];
                vx = vreg_q[x];
                vy = vreg_q[y];
                step = 2;
                case (op)
                    OP_SYS: begin
                        if (nnn == SYS_CLS) begin
                            foreach (frame_q[i]) frame_q[i] = '0;
                            r.redraw = 1'b1;
                        end else if (nnn == SYS_RET) begin
                            sp_q = sp_q - 4'd1;
                            pc_q = stk_q[sp_q];
                        end else begin
                            pc_q = nnn;
                            step = 0;
                        end
                    end
                    OP_JP: begin pc_q = nnn; step = 0; end
                    OP_CALL: begin
                        stk_q[sp_q] = pc_q;
                        stk_ok[sp_q] = 1'b1;
                        sp_q = sp_q + 4'd1;
                        pc_q = nnn;
                        step = 0;
                    end
                    OP_SE:   step = (vx == kk) ? 4 : 2;
                    OP_SNE:  step = (vx != kk) ? 4 : 2;
                    OP_SER:  step = (vx == vy) ? 4 : 2;
                    OP_LD:   vreg_q[x] = kk;
                    OP_ADD:  vreg_q[x] = vx + kk;
                    OP_ALU: begin
                        case (n)
                            AL_MOV: vreg_q[x] = vy;
                            AL_OR:  vreg_q[x] = vx | vy;
                            AL_AND: vreg_q[x] = vx & vy;
                            AL_XOR: vreg_q[x] = vx ^ vy;
                            AL_ADD: begin
                                sum = {1'b0, vx} + {1'b0, vy};
                                vreg_q[15] = {7'd0, sum[8]};
                                vreg_q[x] = sum[7:0];
                            end
                            AL_SUB: begin
                                vreg_q[15] = (vx > vy) ? 8'd1 : 8'd0;
                                vreg_q[x] = vx - vy;
                            end
                            AL_SHR: begin
                                vreg_q[15] = {7'd0, vx[0]};
                                vreg_q[x] = vx >> 1;
                            end
                            AL_SUBN: begin
                                vreg_q[15] = (vy > vx) ? 8'd1 : 8'd0;
                                vreg_q[x] = vy - vx;
                            end
                            AL_SHL: begin
                                vreg_q[15] = {7'd0, vx[7]};
                                vreg_q[x] = vx << 1;
                            end
                            default: begin halt_q = 1'b1; step = 0; end
                        endcase
                    end
                    OP_SNER: begin
                        if (n != 4'd0) begin halt_q = 1'b1; step = 0; end
                        else step = (vx != vy) ? 4 : 2;
                    end
                    OP_LDI: idx_q = nnn;
                    OP_JPV: begin pc_q = nnn + {4'd0, vreg_q[0]}; step = 0; end
                    OP_RND: vreg_q[x] = b.rand_byte & kk;
                    OP_DRW: begin
                        vreg_q[15] = 8'd0;
                        for (int rr = 0; rr < n; rr++) begin
                            bits = mem_q[idx_q + 12'(rr)];
                            yy = vy[4:0] + 5'(rr);
                            for (int c = 0; c < 8; c++) begin
                                if (bits[7 - c]) begin
                                    xx = vx[5:0] + 6'(c);
                                    m = 64'd1 << (63 - xx);
                                    if ((frame_q[yy] & m) != 0) vreg_q[15] = 8'd1;
                                    frame_q[yy] ^= m;
                                end
                            end
                        end
                        r.redraw = 1'b1;
                    end
                    OP_KEY: begin
                        if (kk == K_SKP)
                            step = (vx < 16 && b.keys[vx[3:0]]) ? 4 : 2;
                        else if (kk == K_SKNP)
                            step = (vx < 16 && b.keys[vx[3:0]]) ? 2 : 4;
                        else begin halt_q = 1'b1; step = 0; end
                    end
                    default: begin
                        case (kk)
                            F_GDT: vreg_q[x] = dt_q;
                            F_WKEY: begin
                                any = 0;
                                for (int k = 0; k < 16; k++)
                                    if (b.keys[k]) begin vreg_q[x] = 8'(k); any = 1; end
                                if (!any) begin r.waiting_key = 1'b1; step = 0; end
                            end
                            F_SDT:  dt_q = vx;
                            F_SST:  st_q = vx;
                            F_ADI:  idx_q = idx_q + {4'd0, vx};
                            F_FONT: idx_q = 12'(vx * 5);
                            F_BCD: begin
                                mem_q[idx_q] = 8'(vx / 100);
                                mem_q[idx_q + 12'd1] = 8'((vx / 10) % 10);
                                mem_q[idx_q + 12'd2] = 8'(vx % 10);
                                for (int k = 0; k < 3; k++) mem_ok[idx_q + 12'(k)] = 1'b1;
                            end
                            F_STR:
                                for (int k = 0; k <= x; k++) begin
                                    mem_q[idx_q + 12'(k)] = vreg_q[k];
                                    mem_ok[idx_q + 12'(k)] = 1'b1;
                                end
                            F_LDR:
                                for (int k = 0; k <= x; k++)
                                    vreg_q[k] = mem_q[idx_q + 12'(k)];
                            default: begin halt_q = 1'b1; step = 0; end
                        endcase
                    end
                endcase
                pc_q = pc_q + 12'(step);
            end
            REQ_LOAD: begin
                mem_q[b.mem_addr] = b.mem_data;
                mem_ok[b.mem_addr] = 1'b1;
            end
            REQ_TICK: begin
                if (dt_q != 0) dt_q--;
                if (st_q != 0) st_q--;
            end
            default: r.row_pixels = frame_q[b.display_row];
        endcase
        r.next_pc = pc_q;
        r.bad_opcode = halt_q;
        r.sound_on = (st_q != 0);
        return r;
    endfunction

    // true when the beat would read memory or a stack slot never written
    function automatic bit reads_unwritten(input t_in b);
        logic [3:0] op, n;
        op = b.instr[15:12];
        n = b.instr[3:0];
        if (b.req_type != REQ_EXEC || halt_q) return 0;
        if (op == OP_SYS && b.instr[11:0] == SYS_RET) return !stk_ok[sp_q - 4'd1];
        if (op == OP_DRW)
            for (int k = 0; k < n; k++) if (!mem_ok[idx_q + 12'(k)]) return 1;
        if (op == OP_MISC && b.instr[7:0] == F_LDR)
            for (int k = 0; k <= b.instr[11:8]; k++) if (!mem_ok[idx_q + 12'(k)]) return 1;
        return 0;
    endfunction

    // well-formed random item; unknown opcodes are kept for the final phase
    function automatic t_in random_beat();
        t_in b;
        logic [7:0] fn_list [9];
        logic [3:0] al_list [9];
        logic [3:0] op;
        int pick;
        fn_list = '{F_GDT, F_WKEY, F_SDT, F_SST, F_ADI, F_FONT, F_BCD, F_STR, F_LDR};
        al_list = '{AL_MOV, AL_OR, AL_AND, AL_XOR, AL_ADD, AL_SUB, AL_SHR, AL_SUBN, AL_SHL};
        b.req_type = REQ_EXEC;
        b.instr = 16'($urandom);
        b.mem_addr = 12'($urandom);
        b.mem_data = 8'($urandom);
        b.keys = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        b.rand_byte = 8'($urandom);
        b.display_row = 5'($urandom);
        pick = $urandom_range(99);
        if (pick < 12) begin
            b.req_type = REQ_LOAD;
            // mostly near the sprite area so draws find data
            if ($urandom_range(1)) b.mem_addr = 12'($urandom_range(255));
        end else if (pick < 20) b.req_type = REQ_TICK;
        else if (pick < 30) b.req_type = REQ_ROW;
        else begin
            op = b.instr[15:12];
            case (op)
                OP_SYS: case ($urandom_range(2))
                    0: b.instr[11:0] = SYS_CLS;
                    1: b.instr[11:0] = SYS_RET;
                    default: ;
                endcase
                OP_ALU: b.instr[3:0] = al_list[$urandom_range(8)];
                OP_SNER: b.instr[3:0] = 4'd0;
                OP_LDI: if ($urandom_range(1)) b.instr[11:0] = 12'($urandom_range(240));
                OP_KEY: b.instr[7:0] = $urandom_range(1) ? K_SKP : K_SKNP;
                OP_MISC: b.instr[7:0] = fn_list[$urandom_range(8)];
                default: ;
            endcase
            if (op == OP_SE && $urandom_range(1)) b.instr[7:0] = vreg_q[b.instr[11:8]];
            if (reads_unwritten(b)) b.instr[15:12] = OP_LD;
        end
        return b;
    endfunction

    // offer one beat at the falling edge and hold it until accepted
    task automatic offer(input t_in b, input bit typed, input t_out want);
        t_out p;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        p = predict_outcome(b);
        pending_q.push_back(typed ? want : p);
        req_if.valid <= 1'b1;
        req_if.data <= b;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic offer_random(input int count);
        for (int k = 0; k < count; k++) offer(random_beat(), 0, '0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        wait (pending_q.size() == 0);
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_q.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (rsp_if.data.next_pc !== want.next_pc)
                    report_mismatch("next_pc", 64'(rsp_if.data.next_pc),
                                    64'(want.next_pc));
                if (rsp_if.data.redraw !== want.redraw)
                    report_mismatch("redraw", 64'(rsp_if.data.redraw), 64'(want.redraw));
                if (rsp_if.data.waiting_key !== want.waiting_key)
                    report_mismatch("waiting_key", 64'(rsp_if.data.waiting_key),
                                    64'(want.waiting_key));
                if (rsp_if.data.bad_opcode !== want.bad_opcode)
                    report_mismatch("bad_opcode", 64'(rsp_if.data.bad_opcode),
                                    64'(want.bad_opcode));
                if (rsp_if.data.sound_on !== want.sound_on)
                    report_mismatch("sound_on", 64'(rsp_if.data.sound_on),
                                    64'(want.sound_on));
                if (rsp_if.data.row_pixels !== want.row_pixels)
                    report_mismatch("row_pixels", rsp_if.data.row_pixels, want.row_pixels);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        t_out w;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;

        foreach (vreg_q[i]) vreg_q[i] = '0;
        foreach (mem_q[i]) begin mem_q[i] = '0; mem_ok[i] = 0; end
        foreach (frame_q[i]) frame_q[i] = '0;
        foreach (stk_q[i]) begin stk_q[i] = '0; stk_ok[i] = 0; end
        sp_q = '0;
        pc_q = PC_RESET;
        idx_q = '0;
        dt_q = '0;
        st_q = '0;
        halt_q = 0;

        // directed table; only the first rows carry a typed-in result
        w = '0;
        w.next_pc = PC_RESET;
        dir_tab.push_back('{mk_other(REQ_ROW, 5'd31), 1, w});
        dir_tab.push_back('{mk_other(REQ_TICK, 5'd0), 1, w});
        w.next_pc = PC_RESET + 12'd2;
        w.redraw = 1'b1;
        dir_tab.push_back('{mk_exec({OP_SYS, SYS_CLS}, '0, '0), 1, w});
        w = '0;
        // carry, borrow and shifts, one of them with the flag register as target
        dir_tab.push_back('{mk_exec(ins(OP_LD, 4'h0, 4'hF, 4'hF), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_LD, 4'h1, 4'hF, 4'hF), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_ALU, 4'h0, 4'h1, AL_ADD), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_ALU, 4'hF, 4'h1, AL_SUB), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_ALU, 4'h0, 4'h1, AL_SHR), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_ALU, 4'h1, 4'h0, AL_SHL), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_ALU, 4'h2, 4'h1, AL_SUBN), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_SER, 4'h3, 4'h4, 4'hF), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_SNER, 4'h0, 4'h1, 4'h0), '0, '0), 0, w});
        // sound on, then timers tick down
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h1, F_SST}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h1, F_SDT}, '0, '0), 0, w});
        dir_tab.push_back('{mk_other(REQ_TICK, 5'd0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h5, F_GDT}, '0, '0), 0, w});
        // call and return, jump to the top of memory, pc wrap
        dir_tab.push_back('{mk_exec({OP_CALL, 12'hFFE}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_SYS, SYS_RET}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_JP, 12'hFFE}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_LD, 4'h6, 4'h8, 4'h0), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_SYS, 12'h123}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_JPV, 12'hFFF}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_RND, 4'h3, 8'hFF}, '0, 8'hFF), 0, w});
        // keypad: key index above 15, no key, highest key taken
        dir_tab.push_back('{mk_exec({OP_KEY, 4'h0, K_SKP}, 16'hFFFF, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_KEY, 4'h6, K_SKNP}, 16'h0100, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h4, F_WKEY}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h4, F_WKEY}, 16'h8001, '0), 0, w});
        // sprite across the wrap of memory and screen, drawn twice for collision
        dir_tab.push_back('{mk_load(12'hFFF, 8'hFF), 0, w});
        dir_tab.push_back('{mk_load(12'h000, 8'h81), 0, w});
        dir_tab.push_back('{mk_exec({OP_LDI, 12'hFFF}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_DRW, 4'h1, 4'h1, 4'h2), '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_DRW, 4'h1, 4'h1, 4'h2), '0, '0), 0, w});
        dir_tab.push_back('{mk_other(REQ_ROW, 5'd0), 0, w});
        // font address, bcd, block store and load, empty sprite
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h0, F_FONT}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h0, F_BCD}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'hF, F_STR}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'hF, F_LDR}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec({OP_MISC, 4'h2, F_ADI}, '0, '0), 0, w});
        dir_tab.push_back('{mk_exec(ins(OP_DRW, 4'h0, 4'h0, 4'h0), '0, '0), 0, w});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) offer(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
        drain();

        // fill the sprite area with random bytes
        for (int a = 0; a < 256; a++) offer(mk_load(12'(a), 8'($urandom)), 0, '0);

        // no idling, with one long receiver hold-off in the middle
        offer_random(60);
        hold_req = 1;
        offer_random(100);
        drain();

        src_idle = 73;
        offer_random(180);
        drain();

        src_idle = 0;
        snk_stall = 73;
        offer_random(180);
        drain();

        src_idle = 31;
        snk_stall = 31;
        offer_random(RANDOM_ITEMS - 520);

        // an unknown opcode halts execution; other requests keep working
        offer(mk_exec(ins(OP_ALU, 4'h1, 4'h2, AL_BAD), '0, '0), 0, '0);
        offer_random(20);
        drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
